// ===== hw/rtl/move_to_front_codec_macros.svh =====
// assertion macros used by the checker file mtf_checker.sv
`ifndef MOVE_TO_FRONT_CODEC_MACROS_SVH
`define MOVE_TO_FRONT_CODEC_MACROS_SVH

// property checked outside reset
`define MTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mtf_pkg.sv =====
package mtf_pkg;

    localparam int VALUE_W   = 8;
    localparam int ALPHA_W   = 9;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b1;

    // mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

    typedef logic [VALUE_W-1:0] t_value;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic grab;
        logic first;
        logic walk;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_err;
        logic decode;
        logic match;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/mtf_ram.sv =====
module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mtf_ctrl.sv =====
module mtf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mtf_pkg::t_dp_stat i_stat,
    output mtf_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_GRAB  = 3'd2;
    localparam logic [2:0] ST_FIRST = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_stat.in_err) begin
                        n_state = ST_HOLD;
                    end else if (i_stat.decode) begin
                        n_state = ST_LOOK;
                    end else begin
                        n_state = ST_FIRST;
                    end
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_GRAB;
            end
            ST_GRAB: begin
                o_cmd.grab  = 1'b1;
                o_cmd.first = 1'b1;
                n_state     = ST_WALK;
            end
            ST_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.match) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/mtf_datapath.sv =====
module mtf_datapath #(
    parameter int SYMBOLS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mtf_pkg::t_dp_cmd                    i_cmd,
    output mtf_pkg::t_dp_stat                   o_stat,
    input  logic                                i_cfg_valid,
    input  logic [mtf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mtf_pkg::ALPHA_W-1:0]         i_cfg_data,
    input  mtf_pkg::t_value                     i_value,
    input  logic                                i_block_start,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output mtf_pkg::t_value                     o_out_value,
    output logic                                o_out_err
);

    localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam logic [mtf_pkg::ALPHA_W-1:0] LIMIT_MAX = mtf_pkg::ALPHA_W'(SYMBOLS);

    logic                          r_mode;
    logic [mtf_pkg::ALPHA_W-1:0]   r_alpha;
    logic [SYMBOLS-1:0]            r_valid;
    logic                          r_out_valid;

    mtf_pkg::t_value r_value;
    mtf_pkg::t_value r_target;
    mtf_pkg::t_value r_carry;
    mtf_pkg::t_value r_result;
    logic            r_err;
    mtf_pkg::t_value r_out_value;
    logic            r_out_err;
    logic [AW-1:0]   r_rd_idx;
    logic            r_rd_vld;

    logic [mtf_pkg::ALPHA_W-1:0] limit;
    logic                        in_err;
    logic [AW-1:0]               rd_addr;
    mtf_pkg::t_value             ram_rdata;
    mtf_pkg::t_value             rd_eff;
    logic                        match;

    always_comb begin
        limit  = (r_alpha < LIMIT_MAX) ? r_alpha : LIMIT_MAX;
        in_err = ({1'b0, i_value} >= limit);
    end

    always_comb begin
        priority if (i_cmd.lookup) begin
            rd_addr = r_value[AW-1:0];
        end else if (i_cmd.walk) begin
            rd_addr = AW'(r_rd_idx + 1'b1);
        end else begin
            rd_addr = '0;
        end
    end

    // an entry never written since the last block start reads as its own index
    assign rd_eff = r_rd_vld ? ram_rdata : mtf_pkg::VALUE_W'(r_rd_idx);
    assign match  = (rd_eff == r_target);

    mtf_ram #(
        .WIDTH (mtf_pkg::VALUE_W),
        .DEPTH (SYMBOLS)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (i_cmd.walk),
        .i_waddr (r_rd_idx),
        .i_wdata (r_carry),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= mtf_pkg::MODE_ENCODE;
            r_alpha     <= mtf_pkg::ALPHA_RESET;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mtf_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    mtf_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_block_start) begin
                r_valid <= '0;
            end else if (i_cmd.walk) begin
                r_valid[r_rd_idx] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;
        r_rd_vld <= r_valid[rd_addr];
        if (i_cmd.accept) begin
            r_value  <= i_value;
            r_target <= i_value;
            r_carry  <= i_value;
            r_result <= '0;
            r_err    <= in_err;
        end
        if (i_cmd.grab) begin
            r_target <= rd_eff;
            r_carry  <= rd_eff;
        end
        if (i_cmd.walk) begin
            r_carry <= rd_eff;
            if (match) begin
                r_result <= (r_mode == mtf_pkg::MODE_DECODE) ? r_target
                                                             : mtf_pkg::VALUE_W'(r_rd_idx);
            end
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_result;
            r_out_err   <= r_err;
        end
    end

    assign o_stat.in_err   = in_err;
    assign o_stat.decode   = (r_mode == mtf_pkg::MODE_DECODE);
    assign o_stat.match    = match;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_err   = r_out_err;

endmodule

// ===== hw/rtl/move_to_front_codec.sv =====
// Move-to-front codec. One list of SYMBOLS symbols lives in a single-port-write RAM and starts
// as the identity; in encode mode (mode register 0) each item's symbol gives its position in the
// list, in decode mode (mode register 1) each item's position gives the symbol held there, and
// in both modes that symbol then moves to the front. A set block_start flag (tuser) returns the
// list to the identity before its item, through a bank of per-entry valid bits.
// An input not below min(alphabet limit register, SYMBOLS) returns value 0 with range_error set
// and leaves the list alone but for that block_start reset. Items are handled one at a time:
// the list is walked from the front, one entry per cycle, rewriting each entry through the RAM
// write port. The output register frees the next input while a result still waits to be taken.
// No clearing pass is needed after reset.
// Configuration writes are taken in any cycle and must be made while the block is idle.
module move_to_front_codec #(
    parameter int SYMBOLS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] value_in
    input  logic                          s_axis_tuser,   // [0] block_start
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] value_out
    output logic                          m_axis_tuser,   // [0] range_error
    // configuration writes: index 0 mode, index 1 alphabet limit
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mtf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mtf_pkg::ALPHA_W-1:0]   i_cfg_data
);

    mtf_pkg::t_dp_cmd  cmd;
    mtf_pkg::t_dp_stat stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer: accept, optional lookup of the decode position, list walk, result hand-off
    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // list RAM, valid bits, configuration registers and output register
    mtf_datapath #(
        .SYMBOLS (SYMBOLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_value       (s_axis_tdata),
        .i_block_start (s_axis_tuser),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_value   (m_axis_tdata),
        .o_out_err     (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/mtf_checker.sv =====
`include "move_to_front_codec_macros.svh"

module mtf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [7:0]                    s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [7:0]                    m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [mtf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [mtf_pkg::ALPHA_W-1:0]   i_cfg_data
);

    // a stalled result keeps its payload
    `MTF_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // a flagged result carries value zero
    `MTF_ASSERT(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0, "range error with nonzero value")

    // one item in work at a time
    `MTF_ASSERT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in work")

    // reset empties the output register
    `MTF_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind move_to_front_codec mtf_checker u_mtf_checker (.*);
